FILE: src/bbcd_pkg.sv
`default_nettype none
package bbcd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIGIT_WIDTH = 4;
  // decimal digits needed for the positive range, log10(2) ~ 0.30103
  localparam int BCD_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_WIDTH   = BCD_DIGITS * DIGIT_WIDTH;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(BCD_DIGITS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: src/bbcd_fifo.sv
`default_nettype none
module bbcd_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  bbcd_pkg::value_t     push_value,
  input  wire                  pop,
  output bbcd_pkg::value_t     pop_value,
  output bbcd_pkg::q_status_t  q_status
);

  bbcd_pkg::value_t                  mem [bbcd_pkg::QUEUE_DEPTH];
  logic [bbcd_pkg::QPTR_W-1:0]       wr_ptr;
  logic [bbcd_pkg::QPTR_W-1:0]       rd_ptr;
  logic [bbcd_pkg::QCNT_W-1:0]       count;

  assign q_status.full  = (count == bbcd_pkg::QCNT_W'(bbcd_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_value      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == bbcd_pkg::QPTR_W'(bbcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == bbcd_pkg::QPTR_W'(bbcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && q_status.full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && q_status.empty))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: src/bbcd_front.sv
`default_nettype none
module bbcd_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  bbcd_pkg::value_t     value,
  input  bbcd_pkg::q_status_t  q_status,
  output logic                 push,
  output bbcd_pkg::value_t     push_value
);

  logic             pend_valid;
  bbcd_pkg::value_t pend_value;
  logic             accept;
  logic             positive;

  // zero and negative values produce no digits and are dropped here
  assign positive   = (value != '0) && !value[bbcd_pkg::VALUE_WIDTH-1];
  assign push       = pend_valid && !q_status.full;
  assign in_stall   = pend_valid && q_status.full;
  assign accept     = in_valid && !in_stall;
  assign push_value = pend_value;

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= positive;
    end else if (push) begin
      pend_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   pend_valid |-> (pend_value != '0) && !pend_value[bbcd_pkg::VALUE_WIDTH-1])
    else $error("non-positive value held for conversion");

endmodule
`default_nettype wire

FILE: src/bbcd_back.sv
`default_nettype none
module bbcd_back (
  input  wire                               clk,
  input  wire                               rst,
  input  bbcd_pkg::q_status_t               q_status,
  output logic                              pop,
  input  bbcd_pkg::value_t                  pop_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [bbcd_pkg::DIGIT_WIDTH-1:0]  bcd_digit,
  output logic                              last_digit
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  state_t                              state;
  bbcd_pkg::value_t                    shift;
  logic [bbcd_pkg::BCD_WIDTH-1:0]      bcd;
  logic [bbcd_pkg::BCD_WIDTH-1:0]      bcd_adj;
  logic [bbcd_pkg::BIT_CNT_W-1:0]      bit_cnt;
  logic [bbcd_pkg::DIG_CNT_W-1:0]      rem;
  logic                                started;
  logic [bbcd_pkg::DIGIT_WIDTH-1:0]    top;
  logic                                out_free;
  logic                                emit;

  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign top      = bcd[bbcd_pkg::BCD_WIDTH-1 -: bbcd_pkg::DIGIT_WIDTH];
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == ST_EMIT) && (started || top != '0) && out_free;

  // add-3 correction on every digit before the next shift
  always_comb begin
    for (int i = 0; i < bbcd_pkg::BCD_DIGITS; i++) begin
      if (bcd[i*bbcd_pkg::DIGIT_WIDTH +: bbcd_pkg::DIGIT_WIDTH] >= bbcd_pkg::DIGIT_WIDTH'(5)) begin
        bcd_adj[i*bbcd_pkg::DIGIT_WIDTH +: bbcd_pkg::DIGIT_WIDTH] =
          bcd[i*bbcd_pkg::DIGIT_WIDTH +: bbcd_pkg::DIGIT_WIDTH] + bbcd_pkg::DIGIT_WIDTH'(3);
      end else begin
        bcd_adj[i*bbcd_pkg::DIGIT_WIDTH +: bbcd_pkg::DIGIT_WIDTH] =
          bcd[i*bbcd_pkg::DIGIT_WIDTH +: bbcd_pkg::DIGIT_WIDTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            shift   <= pop_value;
            bcd     <= '0;
            bit_cnt <= '0;
            state   <= ST_CONVERT;
          end
        end
        ST_CONVERT: begin
          bcd     <= {bcd_adj[bbcd_pkg::BCD_WIDTH-2:0], shift[bbcd_pkg::VALUE_WIDTH-1]};
          shift   <= {shift[bbcd_pkg::VALUE_WIDTH-2:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == bbcd_pkg::BIT_CNT_W'(bbcd_pkg::VALUE_WIDTH - 1)) begin
            rem     <= bbcd_pkg::DIG_CNT_W'(bbcd_pkg::BCD_DIGITS);
            started <= 1'b0;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!started && top == '0) begin
            // leading zero, skip without a transfer
            bcd <= {bcd[bbcd_pkg::BCD_WIDTH-bbcd_pkg::DIGIT_WIDTH-1:0],
                    bbcd_pkg::DIGIT_WIDTH'(0)};
            rem <= rem - 1'b1;
          end else if (out_free) begin
            bcd_digit  <= top;
            last_digit <= (rem == bbcd_pkg::DIG_CNT_W'(1));
            bcd <= {bcd[bbcd_pkg::BCD_WIDTH-bbcd_pkg::DIGIT_WIDTH-1:0],
                    bbcd_pkg::DIGIT_WIDTH'(0)};
            rem        <= rem - 1'b1;
            started    <= 1'b1;
            if (rem == bbcd_pkg::DIG_CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> bcd_digit <= bbcd_pkg::DIGIT_WIDTH'(9))
    else $error("digit out of decimal range");
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_EMIT) && !started |-> bcd != '0)
    else $error("positive value converted to all zero digits");

endmodule
`default_nettype wire

FILE: src/binary_to_bcd_digit_stream_unit.sv
// Binary to BCD digit stream.
// Input channel: value (signed, bbcd_pkg::VALUE_WIDTH bits) with in_valid/in_stall.
// Output channel: bcd_digit and last_digit with out_valid/out_stall, one
// transfer per decimal digit, most significant first, leading zeros dropped,
// last_digit set on the least significant digit.
// Zero and negative values are accepted and produce no output at all; they
// are dropped by the front stage at one per cycle while in_stall is low.
// A positive value passes a front register and a two-entry queue into the
// converter, which loads it, shifts in each input bit (32) with add-3
// correction, and walks each digit slot (10) to skip leading zeros or
// send digits. The converter takes the next value from the queue only
// after it has sent the last digit of the current one.
// While the converter works, up to three further items are taken (front
// register and queue), then in_stall rises.
// When out_stall is high with out_valid set, the output digit holds and the
// converter waits; the input side keeps filling the queue independently.
// Reset (rst, synchronous) empties the queue and drops any item in flight.
`default_nettype none
module binary_to_bcd_digit_stream_unit (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [bbcd_pkg::VALUE_WIDTH-1:0]   value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [bbcd_pkg::DIGIT_WIDTH-1:0]  bcd_digit,
  output logic                              last_digit
);

  bbcd_pkg::q_status_t q_status;
  logic                push;
  logic                pop;
  bbcd_pkg::value_t    push_value;
  bbcd_pkg::value_t    pop_value;

  bbcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .q_status   (q_status),
    .push       (push),
    .push_value (push_value)
  );

  bbcd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .pop        (pop),
    .pop_value  (pop_value),
    .q_status   (q_status)
  );

  bbcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop        (pop),
    .pop_value  (pop_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bcd_digit  (bcd_digit),
    .last_digit (last_digit)
  );

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;

  localparam int SETTLE_CYCLES = 64;

  typedef logic [bbcd_pkg::DIGIT_WIDTH-1:0] digit_t;
  typedef struct packed {
    digit_t digit;
    logic   last;
  } digit_rec_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  bbcd_pkg::value_t value;
  logic             out_valid;
  logic             out_stall;
  digit_t           bcd_digit;
  logic             last_digit;

  digit_rec_t pending_digits[$];
  int         mismatch_count;
  bit         source_calm;
  bit         sink_calm;

  binary_to_bcd_digit_stream_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bcd_digit (bcd_digit),
    .last_digit(last_digit)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // decimal digits of a positive value, most significant first
  function automatic void predict_digits(input bbcd_pkg::value_t v);
    bbcd_pkg::value_t rest;
    digit_t           rev[$];
    digit_rec_t       rec;
    int               k;
    if (v == '0 || v[bbcd_pkg::VALUE_WIDTH-1]) return;
    rest = v;
    while (rest != '0) begin
      rev.push_back(digit_t'(rest % 10));
      rest = rest / 10;
    end
    for (k = rev.size() - 1; k >= 0; k--) begin
      rec.digit = rev[k];
      rec.last  = (k == 0);
      pending_digits.push_back(rec);
    end
  endfunction

  // random value with a chosen number of decimal digits
  function automatic bbcd_pkg::value_t value_of_length(input int n);
    longint lo;
    longint hi;
    int     k;
    lo = 1;
    for (k = 1; k < n; k++) lo = lo * 10;
    hi = (n >= 10) ? 64'd2147483647 : lo * 10 - 1;
    return bbcd_pkg::value_t'($urandom_range(int'(hi), int'(lo)));
  endfunction

  task automatic send_value(input bbcd_pkg::value_t v);
    int gap;
    gap = source_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      value    = $urandom();
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value    = v;
    do @(posedge clk); while (in_stall);
    predict_digits(v);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    digit_rec_t exp_rec;
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit transfer: bcd_digit=%0d last_digit=%0b",
               bcd_digit, last_digit);
        mismatch_count++;
      end else begin
        exp_rec = pending_digits.pop_front();
        if (bcd_digit !== exp_rec.digit) begin
          $error("bcd_digit: expected %0d, actual %0d", exp_rec.digit, bcd_digit);
          mismatch_count++;
        end
        if (last_digit !== exp_rec.last) begin
          $error("last_digit: expected %0b, actual %0b", exp_rec.last, last_digit);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!sink_calm && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat (1 + pick_gap()) @(negedge clk);
      end
      out_stall = 1'b0;
    end
  end

  task automatic test_directed_values();
    bbcd_pkg::value_t picks[$];
    picks = '{32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd7, 32'd1000000000,
              32'd1999999999, 32'd2147483647, 32'd1234567890, 32'd987654321,
              32'd1000000001, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000,
              32'd100000, 32'd55555, 32'd2147483646, 32'h4000_0000, 32'd808};
    foreach (picks[k]) send_value(picks[k]);
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    int k;
    source_calm = 1'b1;
    sink_calm   = 1'b1;
    for (k = 0; k < 20; k++) send_value(value_of_length($urandom_range(1, 10)));
    source_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  task automatic test_drain_pause();
    int k;
    for (k = 0; k < 3; k++) send_value(value_of_length($urandom_range(1, 10)));
    wait_drained();
    for (k = 0; k < 3; k++) send_value(value_of_length($urandom_range(1, 10)));
  endtask

  task automatic test_random_values();
    int               positives;
    int               sent;
    int               r;
    longint           p;
    bbcd_pkg::value_t v;
    positives = 0;
    sent      = 0;
    while (positives < 310) begin
      if (sent % 50 == 0) begin
        sink_calm   = ($urandom_range(0, 4) == 0);
        source_calm = ($urandom_range(0, 4) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 68) begin
        v = value_of_length($urandom_range(1, 10));
      end else if (r < 84) begin
        v = $urandom();
      end else if (r < 93) begin
        // around a power of ten
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = bbcd_pkg::value_t'(p + $urandom_range(0, 2) - 1);
      end else if (r < 96) begin
        v = '0;
      end else begin
        v = bbcd_pkg::value_t'(-$signed({1'b0, $urandom_range(1, 32'h7FFF_FFFF)}));
      end
      send_value(v);
      sent++;
      if (v != '0 && !v[bbcd_pkg::VALUE_WIDTH-1]) positives++;
    end
    source_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    value          = '0;
    mismatch_count = 0;
    source_calm    = 1'b0;
    sink_calm      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_values();
    test_back_to_back();
    test_drain_pause();
    test_random_values();
    wait_drained();

    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
